// File: src/cqm_pkg.sv
// package: shared types, op codes and constants of the calligraphy quad mesh
`timescale 1ns / 1ps

package cqm_pkg;

    localparam int VTX_LIMIT = 4096;

    localparam int SQRT_STEPS   = 29;
    localparam int DIV_STEPS    = 18;
    localparam int SHAPE_OFFSET = 5734;
    localparam int SHAPE_RANGE  = 14746;
    localparam int MIN_THICK    = 154;
    localparam int WF_LO        = 77;
    localparam int WF_HI        = 640;
    localparam int ALPHA_ONE    = 32768;
    localparam int XY_MAX       = 524287;
    localparam int XY_MIN       = -524288;

    localparam logic [15:0] RST_STROKE_WIDTH = 16'd256;
    localparam logic [9:0]  RST_WIDTH_FACTOR = 10'd256;
    localparam logic [15:0] RST_OPACITY      = 16'd32768;
    localparam logic [15:0] RST_NIB_COS      = 16'd16384;
    localparam logic [15:0] RST_NIB_SIN      = 16'd0;
    localparam logic [12:0] RST_VCAP         = 13'd4096;
    localparam logic [12:0] RST_ICAP         = 13'd6144;

    typedef enum logic [2:0] {
        CFG_STROKE_WIDTH = 3'd0,
        CFG_WIDTH_FACTOR = 3'd1,
        CFG_OPACITY      = 3'd2,
        CFG_NIB_COS      = 3'd3,
        CFG_NIB_SIN      = 3'd4,
        CFG_VCAP         = 3'd5,
        CFG_ICAP         = 3'd6
    } t_cfg_idx;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL_DX2,
        OP_MUL_DY2,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_MUL_CR1,
        OP_MUL_CR2,
        OP_DIV_CROSS_INIT,
        OP_DIV_STEP,
        OP_MUL_SHAPE,
        OP_MUL_SWWF,
        OP_MUL_SP,
        OP_MUL_HI,
        OP_MUL_LO,
        OP_THICK,
        OP_MUL_OX,
        OP_DIV_OX_INIT,
        OP_DIV_OY_INIT,
        OP_FINISH
    } t_op;

    typedef struct packed {
        logic signed [19:0] pos_x;
        logic signed [19:0] pos_y;
        logic [15:0]        pen_pressure;
        logic               stroke_start;
    } t_in_item;

    typedef struct packed {
        logic signed [19:0] vertex_x;
        logic signed [19:0] vertex_y;
        logic [15:0]        vertex_alpha;
        logic [11:0]        vertex_index;
        logic [1:0]         corner;
        logic               quad_last;
    } t_out_item;

    typedef struct packed {
        t_op        op;
        logic       load_out;
        logic [1:0] corner;
        logic       bump;
    } t_cmd;

    typedef struct packed {
        logic emit;
    } t_stat;

endpackage

// File: src/calligraphy_quad_mesh_top.sv
// top level: calligraphic stroke point to quad corner expander
`timescale 1ns / 1ps

// Takes pen points (x, y, pressure, stroke start) one transfer at a time and,
// for each non-zero segment that fits the vertex and index budget, delivers
// the four corners of a quad around the segment in corner order 0..3, with
// quad_last set on corner 3. Points that open a stroke (which also clears the
// vertex and index counts), repeat the previous point or would overflow a
// capacity only update the stored previous point and produce nothing. A point
// that yields no quad passes a check state and returns to ready; a point that
// yields a quad first runs the op program, dominated by one shared
// 2-bit-per-cycle square root unit and one shared 1-bit-per-cycle divider
// used three times (cross term and both normal offsets), then one corner per
// cycle while the output side takes them. A single output register lets the
// next point transfer while the last corner still waits. Configuration
// registers are written through a plain write port and must only be changed
// while the block is idle.
module calligraphy_quad_mesh_top #(
    parameter int VTX_LIMIT = cqm_pkg::VTX_LIMIT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration write port
    input  logic               i_cfg_wr_en,
    input  logic [2:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_wdata,
    // point input
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  cqm_pkg::t_in_item  i_in,
    // corner output
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output cqm_pkg::t_out_item o_out
);

    cqm_pkg::t_cmd  cmd;
    cqm_pkg::t_stat stat;

    // controller: op sequencing, corner count, output valid
    cqm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // datapath: registers, multiplier, sqrt, divider, output payload
    cqm_dp #(
        .VTX_LIMIT   (VTX_LIMIT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out       (o_out)
    );

`ifndef SYNTHESIS
    // a corner is never loaded over one that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> (!o_out_valid || i_out_ready))
        else $error("corner loaded over a pending transfer");

    // a point is only taken while no segment work is in flight
    a_load_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.op == cqm_pkg::OP_LOAD) |-> (o_in_ready && i_in_valid))
        else $error("point loaded without a transfer");

    // a loaded corner other than corner 3 is on the output in the next cycle
    a_corner_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.load_out && cmd.corner != 2'd3) |=>
            (o_out_valid && o_out.corner == $past(cmd.corner)))
        else $error("corner order broken");
`endif

endmodule

// File: src/cqm_ctrl.sv
// controller: sequences the shared multiplier, square root and divider steps
`timescale 1ns / 1ps

module cqm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  cqm_pkg::t_stat i_stat,
    output cqm_pkg::t_cmd  o_cmd
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CHECK = 5'b00010,
        ST_RUN   = 5'b00100,
        ST_ITER  = 5'b01000,
        ST_EMIT  = 5'b10000
    } t_state;

    // fixed op program for one segment
    function automatic cqm_pkg::t_op prog_op(input logic [3:0] pc);
        cqm_pkg::t_op op;
        case (pc)
            4'd0:    op = cqm_pkg::OP_MUL_DX2;
            4'd1:    op = cqm_pkg::OP_MUL_DY2;
            4'd2:    op = cqm_pkg::OP_SQRT_INIT;
            4'd3:    op = cqm_pkg::OP_MUL_CR1;
            4'd4:    op = cqm_pkg::OP_MUL_CR2;
            4'd5:    op = cqm_pkg::OP_DIV_CROSS_INIT;
            4'd6:    op = cqm_pkg::OP_MUL_SHAPE;
            4'd7:    op = cqm_pkg::OP_MUL_SWWF;
            4'd8:    op = cqm_pkg::OP_MUL_SP;
            4'd9:    op = cqm_pkg::OP_MUL_HI;
            4'd10:   op = cqm_pkg::OP_MUL_LO;
            4'd11:   op = cqm_pkg::OP_THICK;
            4'd12:   op = cqm_pkg::OP_MUL_OX;
            4'd13:   op = cqm_pkg::OP_DIV_OX_INIT;
            4'd14:   op = cqm_pkg::OP_DIV_OY_INIT;
            default: op = cqm_pkg::OP_FINISH;
        endcase
        return op;
    endfunction

    t_state      r_state, n_state;
    logic [3:0]  r_pc, n_pc;
    logic [4:0]  r_cnt, n_cnt;
    logic [1:0]  r_corner, n_corner;
    logic        r_out_valid, n_out_valid;
    cqm_pkg::t_op cur_op;

    assign cur_op = prog_op(r_pc);

    always_comb begin
        n_state      = r_state;
        n_pc         = r_pc;
        n_cnt        = r_cnt;
        n_corner     = r_corner;
        o_in_ready   = 1'b0;
        o_cmd.op     = cqm_pkg::OP_NONE;
        o_cmd.load_out = 1'b0;
        o_cmd.corner = r_corner;
        o_cmd.bump   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = cqm_pkg::OP_LOAD;
                    n_state  = ST_CHECK;
                end
            end
            ST_CHECK: begin
                n_pc    = 4'd0;
                n_state = i_stat.emit ? ST_RUN : ST_IDLE;
            end
            ST_RUN: begin
                o_cmd.op = cur_op;
                if (cur_op == cqm_pkg::OP_SQRT_INIT) begin
                    n_cnt   = 5'(cqm_pkg::SQRT_STEPS - 1);
                    n_state = ST_ITER;
                end else if (cur_op == cqm_pkg::OP_DIV_CROSS_INIT ||
                             cur_op == cqm_pkg::OP_DIV_OX_INIT ||
                             cur_op == cqm_pkg::OP_DIV_OY_INIT) begin
                    n_cnt   = 5'(cqm_pkg::DIV_STEPS - 1);
                    n_state = ST_ITER;
                end else if (cur_op == cqm_pkg::OP_FINISH) begin
                    n_corner = 2'd0;
                    n_state  = ST_EMIT;
                end else begin
                    n_pc = r_pc + 4'd1;
                end
            end
            ST_ITER: begin
                o_cmd.op = (cur_op == cqm_pkg::OP_SQRT_INIT) ? cqm_pkg::OP_SQRT_STEP
                                                             : cqm_pkg::OP_DIV_STEP;
                if (r_cnt == 5'd0) begin
                    n_pc    = r_pc + 4'd1;
                    n_state = ST_RUN;
                end else begin
                    n_cnt = r_cnt - 5'd1;
                end
            end
            ST_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_corner = r_corner + 2'd1;
                    if (r_corner == 2'd3) begin
                        o_cmd.bump = 1'b1;
                        n_state    = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pc        <= 4'd0;
            r_cnt       <= 5'd0;
            r_corner    <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pc        <= n_pc;
            r_cnt       <= n_cnt;
            r_corner    <= n_corner;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// File: src/cqm_dp.sv
// datapath: config registers, stroke state, shared multiplier, sqrt, divider
`timescale 1ns / 1ps

module cqm_dp #(
    parameter int VTX_LIMIT = cqm_pkg::VTX_LIMIT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [2:0]        i_cfg_idx,
    input  logic [15:0]       i_cfg_wdata,
    input  cqm_pkg::t_in_item i_in,
    input  cqm_pkg::t_cmd     i_cmd,
    output cqm_pkg::t_stat    o_stat,
    output cqm_pkg::t_out_item o_out
);

    function automatic logic signed [19:0] sat20(input logic signed [20:0] v);
        logic signed [19:0] r;
        if (v > 21'(cqm_pkg::XY_MAX)) begin
            r = 20'(cqm_pkg::XY_MAX);
        end else if (v < 21'(cqm_pkg::XY_MIN)) begin
            r = 20'(cqm_pkg::XY_MIN);
        end else begin
            r = v[19:0];
        end
        return r;
    endfunction

    // configuration
    logic [15:0]        r_stroke_width;
    logic [9:0]         r_width_factor;
    logic [15:0]        r_opacity;
    logic signed [15:0] r_nib_cos, r_nib_sin;
    logic [12:0]        r_vcap, r_icap;

    // stroke state
    logic signed [19:0] r_prev_x, r_prev_y;
    logic [15:0]        r_prev_p;
    logic               r_have_prev;
    logic [12:0]        r_vcount, r_icount;

    // segment working registers
    logic signed [19:0] r_ax, r_ay, r_bx, r_by;
    logic signed [20:0] r_dx, r_dy;
    logic [16:0]        r_psum;
    logic               r_emit;
    logic signed [49:0] r_prod;
    logic [41:0]        r_l2;
    logic [57:0]        r_sq_op;
    logic [30:0]        r_sq_rem;
    logic [28:0]        r_len;
    logic signed [37:0] r_cr;
    logic [29:0]        r_rem, r_den;
    logic [17:0]        r_qsh;
    logic [16:0]        r_shape;
    logic [25:0]        r_a;
    logic [15:0]        r_b;
    logic [43:0]        r_acc;
    logic [21:0]        r_thick;
    logic signed [18:0] r_ox, r_oy;
    logic [15:0]        r_alpha;
    cqm_pkg::t_out_item r_out;

    logic signed [20:0] ld_dx, ld_dy;
    logic               ld_fit;
    logic [20:0]        dx_mag, dy_mag;
    logic [9:0]         wf_c;
    logic signed [26:0] mul_a;
    logic signed [22:0] mul_b;
    logic signed [49:0] mul_p;
    logic               mul_en;
    logic [41:0]        l2_sum;
    logic [32:0]        sq_rem2, sq_trial;
    logic               sq_ge;
    logic [30:0]        dv_rem2;
    logic               dv_ge;
    logic signed [37:0] cr_diff;
    logic [37:0]        cr_mag;
    logic [47:0]        cross_num, off_num;
    logic [59:0]        thick_full;
    logic [21:0]        thick_raw;
    logic signed [18:0] quot_s;
    logic [16:0]        alpha_raw;
    logic signed [19:0] c_bx, c_by;
    logic signed [20:0] c_vx, c_vy;

    assign ld_dx = 21'(i_in.pos_x) - 21'(r_prev_x);
    assign ld_dy = 21'(i_in.pos_y) - 21'(r_prev_y);
    // quad fits both the vertex and the index budget
    assign ld_fit = (32'(r_vcount) + 32'd4 <= 32'(r_vcap)) &&
                    (32'(r_vcount) + 32'd4 <= 32'(VTX_LIMIT)) &&
                    (32'(r_icount) + 32'd6 <= 32'(r_icap));

    assign dx_mag = r_dx[20] ? 21'(-r_dx) : 21'(r_dx);
    assign dy_mag = r_dy[20] ? 21'(-r_dy) : 21'(r_dy);
    assign wf_c = (r_width_factor < 10'(cqm_pkg::WF_LO)) ? 10'(cqm_pkg::WF_LO) :
                  (r_width_factor > 10'(cqm_pkg::WF_HI)) ? 10'(cqm_pkg::WF_HI) :
                  r_width_factor;

    // shared multiplier operand select
    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b1;
        case (i_cmd.op)
            cqm_pkg::OP_MUL_DX2: begin
                mul_a = {6'b0, dx_mag};
                mul_b = {2'b0, dx_mag};
            end
            cqm_pkg::OP_MUL_DY2: begin
                mul_a = {6'b0, dy_mag};
                mul_b = {2'b0, dy_mag};
            end
            cqm_pkg::OP_MUL_CR1: begin
                mul_a = 27'(r_dx);
                mul_b = 23'(r_nib_sin);
            end
            cqm_pkg::OP_MUL_CR2: begin
                mul_a = 27'(r_dy);
                mul_b = 23'(r_nib_cos);
            end
            cqm_pkg::OP_MUL_SHAPE: begin
                mul_a = {9'b0, r_qsh};
                mul_b = 23'(cqm_pkg::SHAPE_RANGE);
            end
            cqm_pkg::OP_MUL_SWWF: begin
                mul_a = {11'b0, r_stroke_width};
                mul_b = {13'b0, wf_c};
            end
            cqm_pkg::OP_MUL_SP: begin
                mul_a = {10'b0, r_shape};
                mul_b = {6'b0, r_psum};
            end
            // upper half of shape*psum straight from the product register
            cqm_pkg::OP_MUL_HI: begin
                mul_a = {1'b0, r_a};
                mul_b = {5'b0, r_prod[33:16]};
            end
            cqm_pkg::OP_MUL_LO: begin
                mul_a = {1'b0, r_a};
                mul_b = {7'b0, r_b};
            end
            cqm_pkg::OP_MUL_OX: begin
                mul_a = {6'b0, dy_mag};
                mul_b = {1'b0, r_thick};
            end
            cqm_pkg::OP_DIV_OX_INIT: begin
                mul_a = {6'b0, dx_mag};
                mul_b = {1'b0, r_thick};
            end
            cqm_pkg::OP_DIV_OY_INIT: begin
                mul_a = {11'b0, r_opacity};
                mul_b = {6'b0, r_psum};
            end
            default: mul_en = 1'b0;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign l2_sum    = r_l2 + r_prod[41:0];
    assign sq_rem2   = {r_sq_rem, r_sq_op[57:56]};
    assign sq_trial  = {2'b0, r_len, 2'b01};
    assign sq_ge     = sq_rem2 >= sq_trial;
    assign dv_rem2   = {r_rem, r_qsh[17]};
    assign dv_ge     = dv_rem2 >= {1'b0, r_den};
    assign cr_diff   = r_cr - r_prod[37:0];
    assign cr_mag    = cr_diff[37] ? 38'(-cr_diff) : 38'(cr_diff);
    assign cross_num = {2'b0, cr_mag, 8'b0};
    // rounded divide: (2*num + len) / (2*len), num = |d|*thick*8
    assign off_num   = {1'b0, r_prod[42:0], 4'b0} + {19'b0, r_len};
    assign thick_full = {r_acc, 16'b0} + {18'b0, r_prod[41:0]};
    assign thick_raw = thick_full[59:38];
    assign quot_s    = {1'b0, r_qsh};
    assign alpha_raw = r_prod[32:16];

    // corner geometry
    assign c_bx = i_cmd.corner[1] ? r_bx : r_ax;
    assign c_by = i_cmd.corner[1] ? r_by : r_ay;
    assign c_vx = i_cmd.corner[0] ? 21'(c_bx) - 21'(r_ox) : 21'(c_bx) + 21'(r_ox);
    assign c_vy = i_cmd.corner[0] ? 21'(c_by) + 21'(r_oy) : 21'(c_by) - 21'(r_oy);

    // configuration and stroke state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stroke_width <= cqm_pkg::RST_STROKE_WIDTH;
            r_width_factor <= cqm_pkg::RST_WIDTH_FACTOR;
            r_opacity      <= cqm_pkg::RST_OPACITY;
            r_nib_cos      <= cqm_pkg::RST_NIB_COS;
            r_nib_sin      <= cqm_pkg::RST_NIB_SIN;
            r_vcap         <= cqm_pkg::RST_VCAP;
            r_icap         <= cqm_pkg::RST_ICAP;
            r_prev_x       <= '0;
            r_prev_y       <= '0;
            r_prev_p       <= '0;
            r_have_prev    <= 1'b0;
            r_vcount       <= '0;
            r_icount       <= '0;
            r_emit         <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_idx)
                    cqm_pkg::CFG_STROKE_WIDTH: r_stroke_width <= i_cfg_wdata;
                    cqm_pkg::CFG_WIDTH_FACTOR: r_width_factor <= i_cfg_wdata[9:0];
                    cqm_pkg::CFG_OPACITY:      r_opacity      <= i_cfg_wdata;
                    cqm_pkg::CFG_NIB_COS:      r_nib_cos      <= i_cfg_wdata;
                    cqm_pkg::CFG_NIB_SIN:      r_nib_sin      <= i_cfg_wdata;
                    cqm_pkg::CFG_VCAP:         r_vcap         <= i_cfg_wdata[12:0];
                    cqm_pkg::CFG_ICAP:         r_icap         <= i_cfg_wdata[12:0];
                    default: ;
                endcase
            end
            if (i_cmd.op == cqm_pkg::OP_LOAD) begin
                r_prev_x    <= i_in.pos_x;
                r_prev_y    <= i_in.pos_y;
                r_prev_p    <= i_in.pen_pressure;
                r_have_prev <= 1'b1;
                r_emit      <= r_have_prev && !i_in.stroke_start &&
                               (ld_dx != '0 || ld_dy != '0) && ld_fit;
                if (i_in.stroke_start) begin
                    r_vcount <= '0;
                    r_icount <= '0;
                end
            end else if (i_cmd.bump) begin
                r_vcount <= r_vcount + 13'd4;
                r_icount <= r_icount + 13'd6;
            end
        end
    end

    // arithmetic working registers
    always_ff @(posedge i_clk) begin
        if (mul_en) begin
            r_prod <= mul_p;
        end
        case (i_cmd.op)
            cqm_pkg::OP_LOAD: begin
                r_ax   <= r_prev_x;
                r_ay   <= r_prev_y;
                r_bx   <= i_in.pos_x;
                r_by   <= i_in.pos_y;
                r_dx   <= ld_dx;
                r_dy   <= ld_dy;
                r_psum <= {1'b0, r_prev_p} + {1'b0, i_in.pen_pressure};
            end
            cqm_pkg::OP_MUL_DY2: r_l2 <= r_prod[41:0];
            cqm_pkg::OP_SQRT_INIT: begin
                r_sq_op  <= {l2_sum, 16'b0};
                r_sq_rem <= '0;
                r_len    <= '0;
            end
            cqm_pkg::OP_SQRT_STEP: begin
                r_sq_rem <= sq_ge ? 31'(sq_rem2 - sq_trial) : sq_rem2[30:0];
                r_len    <= {r_len[27:0], sq_ge};
                r_sq_op  <= {r_sq_op[55:0], 2'b00};
            end
            cqm_pkg::OP_MUL_CR2: r_cr <= r_prod[37:0];
            cqm_pkg::OP_DIV_CROSS_INIT: begin
                r_rem <= cross_num[47:18];
                r_qsh <= cross_num[17:0];
                r_den <= {1'b0, r_len};
            end
            cqm_pkg::OP_DIV_STEP: begin
                r_rem <= dv_ge ? 30'(dv_rem2 - {1'b0, r_den}) : dv_rem2[29:0];
                r_qsh <= {r_qsh[16:0], dv_ge};
            end
            cqm_pkg::OP_MUL_SWWF:
                r_shape <= 17'(cqm_pkg::SHAPE_OFFSET) + 17'(r_prod[31:14]);
            cqm_pkg::OP_MUL_SP: r_a   <= r_prod[25:0];
            cqm_pkg::OP_MUL_HI: r_b   <= r_prod[15:0];
            cqm_pkg::OP_MUL_LO: r_acc <= r_prod[43:0];
            cqm_pkg::OP_THICK:
                r_thick <= (thick_raw < 22'(cqm_pkg::MIN_THICK)) ?
                           22'(cqm_pkg::MIN_THICK) : thick_raw;
            cqm_pkg::OP_DIV_OX_INIT: begin
                r_rem <= off_num[47:18];
                r_qsh <= off_num[17:0];
                r_den <= {r_len, 1'b0};
            end
            cqm_pkg::OP_DIV_OY_INIT: begin
                r_ox  <= r_dy[20] ? -quot_s : quot_s;
                r_rem <= off_num[47:18];
                r_qsh <= off_num[17:0];
            end
            cqm_pkg::OP_FINISH: begin
                r_oy    <= r_dx[20] ? -quot_s : quot_s;
                r_alpha <= (alpha_raw > 17'(cqm_pkg::ALPHA_ONE)) ?
                           16'(cqm_pkg::ALPHA_ONE) : alpha_raw[15:0];
            end
            default: ;
        endcase
        if (i_cmd.load_out) begin
            r_out.vertex_x     <= sat20(c_vx);
            r_out.vertex_y     <= sat20(c_vy);
            r_out.vertex_alpha <= r_alpha;
            r_out.vertex_index <= r_vcount[11:0] + {10'b0, i_cmd.corner};
            r_out.corner       <= i_cmd.corner;
            r_out.quad_last    <= (i_cmd.corner == 2'd3);
        end
    end

    assign o_stat.emit = r_emit;
    assign o_out       = r_out;

endmodule
